// ===== rtl/core/servo_angle_to_pulse_control_unit_assert.svh =====
`ifndef SERVO_ANGLE_TO_PULSE_CONTROL_UNIT_ASSERT_SVH
`define SERVO_ANGLE_TO_PULSE_CONTROL_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SAPC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sapc assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define SAPC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sapc assertion failed");

`endif

// ===== rtl/core/sapc_pkg.sv =====
package sapc_pkg;

    localparam int ANGLE_W    = 8;
    localparam int PULSE_W    = 16;
    localparam int TICK_W     = 16;
    localparam int DIVD_W     = 32;
    localparam int DIVS_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_BITS_PER_CYC = 2;
    localparam int DIV_CYC          = DIVD_W / DIV_BITS_PER_CYC;
    localparam int DIV_CNT_W        = $clog2(DIV_CYC);

    localparam logic [ANGLE_W-1:0] ANGLE_CAP = 8'd180;

    localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE   = 8'd0;
    localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE   = 8'd180;
    localparam logic [PULSE_W-1:0] RST_MIN_PULSE   = 16'd1000;
    localparam logic [PULSE_W-1:0] RST_MAX_PULSE   = 16'd2000;
    localparam logic [ANGLE_W-1:0] RST_START_ANGLE = 8'd90;

    typedef enum logic [1:0] {
        OP_START,
        OP_SET,
        OP_INC,
        OP_DEC
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ANGLE,
        CFG_MAX_ANGLE,
        CFG_MIN_PULSE,
        CFG_MAX_PULSE,
        CFG_START_ANGLE
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANGLE,
        S_RANGE,
        S_MUL,
        S_MAP_GO,
        S_MAP_WAIT,
        S_PULSE,
        S_SCALE,
        S_TICK,
        S_COMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic angle;
        logic range;
        logic mul;
        logic div_start;
        logic tick;
        logic pulse;
        logic scale;
        logic commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic div_busy;
        logic div_done;
    } t_status;

endpackage

// ===== rtl/core/servo_angle_to_pulse_control_unit.sv =====
// a command is taken only in the idle state, so the next one waits until the last result is
// loaded into the output register; an accepted command waits on the radix-4 divider for the
// angle-to-pulse mapping, and one ignored before start skips it
// a result may wait in the output register while the next command is taken
// reset (synchronous, active low): registers to defaults, not started, angle and ticks 0
module servo_angle_to_pulse_control_unit #(
    parameter int CLOCK_MHZ = 16,
    parameter int PRESCALE  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_opcode,
    input  logic [sapc_pkg::ANGLE_W-1:0]     i_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sapc_pkg::TICK_W-1:0]      o_pulse_cmp,
    output logic [sapc_pkg::ANGLE_W-1:0]     o_angle,
    output logic                             o_accepted,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sapc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sapc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sapc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sapc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sapc_dp #(
        .CLOCK_MHZ (CLOCK_MHZ),
        .PRESCALE  (PRESCALE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_pulse_cmp (o_pulse_cmp),
        .o_angle     (o_angle),
        .o_accepted  (o_accepted)
    );

endmodule

// ===== rtl/core/sapc_div.sv =====
module sapc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sapc_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [sapc_pkg::DIVS_W-1:0]   i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [sapc_pkg::DIVD_W-1:0]   o_quotient
);
    import sapc_pkg::*;

    logic [DIVD_W-1:0]    r_quo;
    logic [DIVD_W-1:0]    n_quo;
    logic [DIVS_W-1:0]    r_rem;
    logic [DIVS_W-1:0]    n_rem;
    logic [DIVS_W-1:0]    r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIVS_W:0]      step_sh;

    // restoring division, two quotient bits per cycle
    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        step_sh = '0;
        for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
            step_sh = {n_rem, n_quo[DIVD_W-1]};
            n_quo   = {n_quo[DIVD_W-2:0], 1'b0};
            if (step_sh >= {1'b0, r_dvs}) begin
                step_sh  = step_sh - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = step_sh[DIVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/sapc_dp.sv =====
module sapc_dp #(
    parameter int CLOCK_MHZ = 16,
    parameter int PRESCALE  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sapc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sapc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]                       i_opcode,
    input  logic [sapc_pkg::ANGLE_W-1:0]     i_value,
    input  sapc_pkg::t_cmd                   i_cmd,
    output sapc_pkg::t_status                o_status,
    output logic [sapc_pkg::TICK_W-1:0]      o_pulse_cmp,
    output logic [sapc_pkg::ANGLE_W-1:0]     o_angle,
    output logic                             o_accepted
);
    import sapc_pkg::*;

    localparam int PAD_W    = PULSE_W - ANGLE_W;
    localparam int MHZ_W    = $clog2(CLOCK_MHZ + 1);
    localparam int SCALED_W = PULSE_W + MHZ_W;
    localparam int RECIP_SH = SCALED_W + $clog2(PRESCALE);
    localparam int RECIP_W  = SCALED_W + 2;
    localparam int TPROD_W  = SCALED_W + RECIP_W;

    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(PRESCALE) - 64'd1) / 64'(PRESCALE);
    localparam logic [SCALED_W-1:0] CLK_MULT = SCALED_W'(CLOCK_MHZ);
    localparam logic [RECIP_W-1:0]  RECIP    = RECIP_FULL[RECIP_W-1:0];

    logic [ANGLE_W-1:0] r_min_angle;
    logic [ANGLE_W-1:0] r_max_angle;
    logic [PULSE_W-1:0] r_min_pulse;
    logic [PULSE_W-1:0] r_max_pulse;
    logic [ANGLE_W-1:0] r_start_angle;

    logic               r_started;
    logic [ANGLE_W-1:0] r_cur_angle;
    logic [TICK_W-1:0]  r_cmp;

    t_op                r_op;
    logic [ANGLE_W-1:0] r_val;
    logic               r_acc;
    logic [ANGLE_W-1:0] r_angle;
    logic [PULSE_W-1:0] r_off;
    logic [PULSE_W-1:0] r_arange;
    logic [PULSE_W-1:0] r_prange;
    logic [DIVD_W-1:0]  r_prod;
    logic [PULSE_W-1:0] r_pulse;
    logic [SCALED_W-1:0] r_scaled;
    logic [TPROD_W-1:0] r_tick_prod;
    logic [TICK_W-1:0]  r_out_ticks;
    logic [ANGLE_W-1:0] r_out_angle;
    logic               r_out_acc;

    logic               skip;
    logic [ANGLE_W:0]   inc_sum;
    logic [ANGLE_W-1:0] tgt;
    logic [ANGLE_W-1:0] lo_angle;
    logic [ANGLE_W-1:0] clamp_angle;
    logic [PULSE_W-1:0] mapped;
    logic [PULSE_W-1:0] lo_pulse;
    logic [PULSE_W-1:0] clamp_pulse;
    logic [TPROD_W-1:0] tick_shift;
    logic [SCALED_W-1:0] tick_quo;
    logic [TICK_W-1:0]  sat_ticks;

    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic               div_busy;
    logic               div_done;
    logic [DIVD_W-1:0]  div_quo;

    assign skip = (r_op != OP_START) && !r_started;

    // target angle for the command, then clamp to the angle window
    always_comb begin
        inc_sum = {1'b0, r_cur_angle} + {1'b0, r_val};
        case (r_op)
            OP_START: tgt = r_start_angle;
            OP_SET:   tgt = r_val;
            OP_INC:   tgt = (inc_sum > {1'b0, ANGLE_CAP}) ? ANGLE_CAP : inc_sum[ANGLE_W-1:0];
            OP_DEC:   tgt = (r_val > r_cur_angle) ? '0 : r_cur_angle - r_val;
            default:  tgt = r_val;
        endcase
        lo_angle    = (tgt < r_min_angle) ? r_min_angle : tgt;
        clamp_angle = (lo_angle > r_max_angle) ? r_max_angle : lo_angle;
    end

    // mapped pulse, then clamp to the pulse window
    // ticks by reciprocal multiply, exact over the whole scaled pulse range
    always_comb begin
        mapped      = (r_arange == '0) ? r_min_pulse : r_min_pulse + div_quo[PULSE_W-1:0];
        lo_pulse    = (mapped < r_min_pulse) ? r_min_pulse : mapped;
        clamp_pulse = (lo_pulse > r_max_pulse) ? r_max_pulse : lo_pulse;
        tick_shift  = r_tick_prod >> RECIP_SH;
        tick_quo    = tick_shift[SCALED_W-1:0];
        sat_ticks   = (|tick_quo[SCALED_W-1:TICK_W]) ? '1 : tick_quo[TICK_W-1:0];
    end

    assign div_dividend = r_prod;
    assign div_divisor  = r_arange;

    sapc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_angle   <= RST_MIN_ANGLE;
            r_max_angle   <= RST_MAX_ANGLE;
            r_min_pulse   <= RST_MIN_PULSE;
            r_max_pulse   <= RST_MAX_PULSE;
            r_start_angle <= RST_START_ANGLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_ANGLE:   r_min_angle   <= i_cfg_data[ANGLE_W-1:0];
                CFG_MAX_ANGLE:   r_max_angle   <= i_cfg_data[ANGLE_W-1:0];
                CFG_MIN_PULSE:   r_min_pulse   <= i_cfg_data[PULSE_W-1:0];
                CFG_MAX_PULSE:   r_max_pulse   <= i_cfg_data[PULSE_W-1:0];
                CFG_START_ANGLE: r_start_angle <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_cur_angle <= '0;
            r_cmp       <= '0;
        end else if (i_cmd.commit) begin
            r_cur_angle <= r_angle;
            r_cmp       <= sat_ticks;
            if (r_op == OP_START) begin
                r_started <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_opcode);
            r_val <= i_value;
        end
        if (i_cmd.angle) begin
            r_angle <= clamp_angle;
            r_acc   <= !skip;
        end
        if (i_cmd.range) begin
            r_off    <= {{PAD_W{1'b0}}, r_angle} - {{PAD_W{1'b0}}, r_min_angle};
            r_arange <= {{PAD_W{1'b0}}, r_max_angle} - {{PAD_W{1'b0}}, r_min_angle};
            r_prange <= r_max_pulse - r_min_pulse;
        end
        if (i_cmd.mul) begin
            r_prod <= {{(DIVD_W-PULSE_W){1'b0}}, r_off} * {{(DIVD_W-PULSE_W){1'b0}}, r_prange};
        end
        if (i_cmd.pulse) begin
            r_pulse <= clamp_pulse;
        end
        if (i_cmd.scale) begin
            r_scaled <= {{MHZ_W{1'b0}}, r_pulse} * CLK_MULT;
        end
        if (i_cmd.tick) begin
            r_tick_prod <= {{RECIP_W{1'b0}}, r_scaled} * {{SCALED_W{1'b0}}, RECIP};
        end
        if (i_cmd.out_load) begin
            r_out_ticks <= r_cmp;
            r_out_angle <= r_cur_angle;
            r_out_acc   <= r_acc;
        end
    end

    assign o_status.skip     = skip;
    assign o_status.div_busy = div_busy;
    assign o_status.div_done = div_done;

    assign o_pulse_cmp = r_out_ticks;
    assign o_angle     = r_out_angle;
    assign o_accepted  = r_out_acc;

endmodule

// ===== rtl/core/sapc_ctrl.sv =====
`include "servo_angle_to_pulse_control_unit_assert.svh"

module sapc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  sapc_pkg::t_status  i_status,
    output sapc_pkg::t_cmd     o_cmd
);
    import sapc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ANGLE;
                end
            end
            S_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state     = i_status.skip ? S_OUT : S_RANGE;
            end
            S_RANGE: begin
                o_cmd.range = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MAP_GO;
            end
            S_MAP_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_MAP_WAIT;
            end
            S_MAP_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_PULSE;
                end
            end
            S_PULSE: begin
                o_cmd.pulse = 1'b1;
                n_state     = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_TICK;
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                n_state    = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output slot is free again once its item is taken
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    `SAPC_ASSERT_NXT(a_accept_busy, o_ready && i_valid, !o_ready)
    `SAPC_ASSERT_IMP(a_load_slot_free, o_cmd.out_load, !r_out_valid || i_ready)
    `SAPC_ASSERT_IMP(a_div_start_idle, o_cmd.div_start, !i_status.div_busy)
    `SAPC_ASSERT_NXT(a_map_done_next, (r_state == S_MAP_WAIT) && i_status.div_done,
                     r_state == S_PULSE)

endmodule

// ===== test/servo_angle_to_pulse_control_unit_tb.sv =====
`timescale 1ns / 1ps

module servo_angle_to_pulse_control_unit_tb;
    import sapc_pkg::*;

    localparam int unsigned CLOCK_MHZ = 16;
    localparam int unsigned PRESCALE = 8;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned PHASE_ITEMS = 123;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        t_op op;
        logic [ANGLE_W-1:0] value;
    } t_servo_cmd;

    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic [ANGLE_W-1:0] angle;
        logic accepted;
    } t_servo_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_opcode = OP_START;
    logic [ANGLE_W-1:0] i_value = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [TICK_W-1:0] o_pulse_cmp;
    logic [ANGLE_W-1:0] o_angle;
    logic o_accepted;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor copy of the configuration and state
    logic [ANGLE_W-1:0] lim_min_angle = RST_MIN_ANGLE;
    logic [ANGLE_W-1:0] lim_max_angle = RST_MAX_ANGLE;
    logic [PULSE_W-1:0] lim_min_pulse = RST_MIN_PULSE;
    logic [PULSE_W-1:0] lim_max_pulse = RST_MAX_PULSE;
    logic [ANGLE_W-1:0] home_angle = RST_START_ANGLE;
    logic servo_started = 1'b0;
    logic [ANGLE_W-1:0] servo_angle = '0;
    logic [TICK_W-1:0] servo_ticks = '0;

    t_servo_cmd cmd_q[$];
    t_servo_result servo_results_q[$];
    t_servo_cmd next_cmd;
    t_servo_result got_result;
    t_servo_result want_result;

    int unsigned mismatches = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    bit hold_req = 1'b0;
    bit quiet = 1'b0;

    servo_angle_to_pulse_control_unit #(
        .CLOCK_MHZ(CLOCK_MHZ),
        .PRESCALE(PRESCALE)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_opcode(i_opcode),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_pulse_cmp(o_pulse_cmp),
        .o_angle(o_angle),
        .o_accepted(o_accepted),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [PULSE_W-1:0] angle_to_pulse(input logic [ANGLE_W-1:0] a);
        logic [15:0] arange;
        logic [15:0] prange;
        logic [15:0] offs;
        logic [31:0] quot;
        arange = 16'(lim_max_angle) - 16'(lim_min_angle);
        prange = lim_max_pulse - lim_min_pulse;
        offs = 16'(a) - 16'(lim_min_angle);
        if (arange == 16'd0) begin
            return lim_min_pulse;
        end
        quot = (32'(offs) * 32'(prange)) / 32'(arange);
        return lim_min_pulse + quot[15:0];
    endfunction

    function automatic void move_to(input logic [ANGLE_W-1:0] target);
        logic [ANGLE_W-1:0] a;
        logic [PULSE_W-1:0] p;
        logic [31:0] t;
        a = target;
        if (a < lim_min_angle) a = lim_min_angle;
        if (a > lim_max_angle) a = lim_max_angle;
        p = angle_to_pulse(a);
        if (p < lim_min_pulse) p = lim_min_pulse;
        if (p > lim_max_pulse) p = lim_max_pulse;
        t = (32'(p) * CLOCK_MHZ) / PRESCALE;
        servo_ticks = (t > 32'hFFFF) ? 16'hFFFF : t[15:0];
        servo_angle = a;
    endfunction

    function automatic t_servo_result apply_command(input t_op op, input logic [ANGLE_W-1:0] v);
        t_servo_result r;
        logic [ANGLE_W:0] sum;
        r.accepted = 1'b1;
        if (op == OP_START) begin
            servo_started = 1'b1;
            servo_angle = home_angle;
            move_to(home_angle);
        end else if (!servo_started) begin
            r.accepted = 1'b0;
        end else if (op == OP_SET) begin
            move_to(v);
        end else if (op == OP_INC) begin
            sum = {1'b0, servo_angle} + {1'b0, v};
            if (sum > {1'b0, ANGLE_CAP}) sum = {1'b0, ANGLE_CAP};
            move_to(sum[ANGLE_W-1:0]);
        end else if (v > servo_angle) begin
            move_to('0);
        end else begin
            move_to(servo_angle - v);
        end
        r.ticks = servo_ticks;
        r.angle = servo_angle;
        return r;
    endfunction

    function automatic t_servo_cmd random_cmd();
        t_servo_cmd c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) c.op = OP_START;
        else if (pick < 44) c.op = OP_SET;
        else if (pick < 72) c.op = OP_INC;
        else c.op = OP_DEC;
        c.value = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
        return c;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_cmd(input t_op op, input logic [ANGLE_W-1:0] v);
        t_servo_cmd c;
        c.op = op;
        c.value = v;
        cmd_q.push_back(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input logic [15:0] min_a, input logic [15:0] max_a,
                              input logic [15:0] min_p, input logic [15:0] max_p,
                              input logic [15:0] start_a);
        write_reg(CFG_MIN_ANGLE, min_a);
        write_reg(CFG_MAX_ANGLE, max_a);
        write_reg(CFG_MIN_PULSE, min_p);
        write_reg(CFG_MAX_PULSE, max_p);
        write_reg(CFG_START_ANGLE, start_a);
    endtask

    // sampled mid-cycle so the driver's updates at the edge have settled
    task automatic drain();
        while (cmd_q.size() != 0 || i_valid || servo_results_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned n);
        push_cmd(OP_START, 8'($urandom));
        repeat (n) cmd_q.push_back(random_cmd());
        drain();
    endtask

    // command driver and prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                servo_results_q.push_back(apply_command(t_op'(i_opcode), i_value));
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (cmd_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 14);
                    i_valid <= 1'b0;
                end else begin
                    next_cmd = cmd_q.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= next_cmd.op;
                    i_value <= next_cmd.value;
                end
            end
        end
    end

    // result side ready, with random bursts and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_result.ticks = o_pulse_cmp;
            got_result.angle = o_angle;
            got_result.accepted = o_accepted;
            if (servo_results_q.size() == 0) begin
                $display("%0t: unexpected item: expected none, actual ticks %0d angle %0d acc %0d",
                         $time, got_result.ticks, got_result.angle, got_result.accepted);
                mismatches++;
            end else begin
                want_result = servo_results_q.pop_front();
                check_field("pulse_cmp", want_result.ticks, got_result.ticks);
                check_field("angle", want_result.angle, got_result.angle);
                check_field("accepted", want_result.accepted, got_result.accepted);
            end
        end
    end

    // predictor follows register writes
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_ANGLE: lim_min_angle = i_cfg_data[ANGLE_W-1:0];
                CFG_MAX_ANGLE: lim_max_angle = i_cfg_data[ANGLE_W-1:0];
                CFG_MIN_PULSE: lim_min_pulse = i_cfg_data[PULSE_W-1:0];
                CFG_MAX_PULSE: lim_max_pulse = i_cfg_data[PULSE_W-1:0];
                CFG_START_ANGLE: home_angle = i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // commands before start are ignored
        push_cmd(OP_SET, 8'd255);
        push_cmd(OP_INC, 8'd10);
        push_cmd(OP_DEC, 8'd255);
        push_cmd(OP_START, 8'd0);
        push_cmd(OP_SET, 8'd0);
        push_cmd(OP_SET, 8'd255);
        push_cmd(OP_SET, 8'd180);
        push_cmd(OP_SET, 8'd90);
        push_cmd(OP_INC, 8'd255);
        push_cmd(OP_INC, 8'd0);
        push_cmd(OP_DEC, 8'd10);
        push_cmd(OP_DEC, 8'd255);
        push_cmd(OP_DEC, 8'd0);
        push_cmd(OP_INC, 8'd170);
        push_cmd(OP_INC, 8'd15);
        push_cmd(OP_START, 8'd255);
        push_cmd(OP_DEC, 8'd90);
        push_cmd(OP_SET, 8'd85);
        drain();

        // widest ranges, ticks saturate
        set_limits(16'd0, 16'd255, 16'd0, 16'd65535, 16'd255);
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS);

        // zero angle range
        set_limits(16'd50, 16'd50, 16'd1500, 16'd2500, 16'd10);
        run_phase(PHASE_ITEMS);

        // inverted angle range
        set_limits(16'd200, 16'd20, 16'd1000, 16'd2000, 16'd100);
        run_phase(PHASE_ITEMS);

        // inverted pulse range
        set_limits(16'd0, 16'd180, 16'd3000, 16'd500, 16'd90);
        run_phase(PHASE_ITEMS);

        set_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(PHASE_ITEMS);

        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_UNUSED_IDX, 16'h5A5A);
        run_phase(PHASE_ITEMS);

        set_limits(16'd10, 16'd170, 16'd600, 16'd2400, 16'd45);
        run_phase(PHASE_ITEMS);

        repeat (2) begin
            set_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
            run_phase(PHASE_ITEMS);
        end

        quiet = 1'b1;
        set_limits(16'(RST_MIN_ANGLE), 16'(RST_MAX_ANGLE), RST_MIN_PULSE, RST_MAX_PULSE,
                   16'(RST_START_ANGLE));
        run_phase(PHASE_ITEMS);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
